@@ src/first_fit_free_list_allocator_macros.svh @@
// Assertion macros for the first-fit free-list allocator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define FFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ffa_pkg.sv @@
// Shared types, codes and constants of the first-fit free-list allocator.
// No dependencies; used by every other RTL file but ffa_ram, by scoped names.
package ffa_pkg;

   localparam int FREE_ENTRIES_DEF = 64;
   localparam int HEADER_BYTES_DEF = 16;
   localparam logic [31:0] HEAP_RESET = 32'h8000_0000;
   localparam logic [32:0] HEAP_LIMIT = 33'h0_8000_0000;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_REUSED = 3'd0,
      ST_BUMPED = 3'd1,
      ST_FREED  = 3'd2,
      ST_OOM    = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   typedef struct packed {
      func_type    func;
      logic [30:0] req_size;
      logic [30:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [30:0] data_addr;
      logic [30:0] granted_size;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic [30:0] addr;
      logic [30:0] size;
   } entry_type;

   typedef struct packed {
      logic        fits;
      logic [30:0] data_addr;
   } bump_status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_SHIFT,
      SEQ_BUMP
   } seq_state_type;

endpackage

@@ src/ffa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ffa_bump.sv @@
// Bump unit: heap size register, frontier register and the out-of-memory check.
// Depends on ffa_pkg.
module ffa_bump #(
   parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [31:0]              csr_wdata,
   input  logic [30:0]              req_size,
   input  logic                     commit,
   output ffa_pkg::bump_status_type status
);

   logic [31:0] heap_ff;
   logic [31:0] frontier_ff;
   logic [31:0] frontier_in;
   logic [32:0] data_sum;
   logic [32:0] end_sum;
   logic [32:0] limit;

   always_comb begin
      data_sum    = {1'b0, frontier_ff} + 33'(HEADER_BYTES);
      end_sum     = data_sum + {2'b00, req_size};
      // saturate the limit at 2^31
      limit       = heap_ff[31] ? ffa_pkg::HEAP_LIMIT : {1'b0, heap_ff};
      status.fits = (end_sum <= limit) && (data_sum[32:31] == 2'b00);
      status.data_addr = data_sum[30:0];
      frontier_in = commit ? end_sum[31:0] : frontier_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff     <= ffa_pkg::HEAP_RESET;
         frontier_ff <= '0;
      end else begin
         if (csr_we) begin
            heap_ff <= csr_wdata;
         end
         frontier_ff <= frontier_in;
      end
   end

endmodule

@@ src/ffa_seq.sv @@
// Sequencer: free-list count, scan of the list memory, unlink by shifting, responses.
// Depends on ffa_pkg and the assertion macros header.
`include "first_fit_free_list_allocator_macros.svh"

module ffa_seq #(
   parameter int FREE_ENTRIES = ffa_pkg::FREE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  ffa_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output ffa_pkg::rsp_type                rsp_data,
   output logic [30:0]                     bump_size,
   output logic                            bump_commit,
   input  ffa_pkg::bump_status_type        bump_status,
   output logic                            ram_wr_en,
   output logic [$clog2(FREE_ENTRIES)-1:0] ram_wr_addr,
   output ffa_pkg::entry_type              ram_wr_data,
   output logic [$clog2(FREE_ENTRIES)-1:0] ram_rd_addr,
   input  ffa_pkg::entry_type              ram_rd_data
);

   localparam int IDX_W = $clog2(FREE_ENTRIES);
   localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

   ffa_pkg::seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       ptr_ff, ptr_in;
   logic [IDX_W-1:0]       widx_ff, widx_in;
   logic [30:0]            req_ff, req_in;
   ffa_pkg::entry_type     held_ff, held_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ffa_pkg::rsp_type       rsp_ff, rsp_in;

   logic             accept;
   logic             hit;
   logic             full;
   logic [IDX_W-1:0] last_idx;

   assign accept   = start && (state_ff == ffa_pkg::SEQ_IDLE);
   assign hit      = ram_rd_data.size >= req_ff;
   assign full     = count_ff == CNT_W'(FREE_ENTRIES);
   assign last_idx = IDX_W'(count_ff - 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffa_pkg::SEQ_IDLE: begin
            if (accept && req_data.func == ffa_pkg::FUNC_ALLOC) begin
               state_in = (count_ff == '0) ? ffa_pkg::SEQ_BUMP : ffa_pkg::SEQ_SCAN;
            end
         end
         ffa_pkg::SEQ_SCAN: begin
            if (hit) begin
               state_in = (ptr_ff == last_idx) ? ffa_pkg::SEQ_IDLE : ffa_pkg::SEQ_SHIFT;
            end else if (ptr_ff == '0) begin
               state_in = ffa_pkg::SEQ_BUMP;
            end
         end
         ffa_pkg::SEQ_SHIFT: begin
            if (IDX_W'(widx_ff + 1'b1) == last_idx) begin
               state_in = ffa_pkg::SEQ_IDLE;
            end
         end
         ffa_pkg::SEQ_BUMP: begin
            state_in = ffa_pkg::SEQ_IDLE;
         end
         default: begin
            state_in = ffa_pkg::SEQ_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      widx_in      = widx_ff;
      req_in       = req_ff;
      held_in      = held_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_rd_addr  = ptr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = widx_ff;
      ram_wr_data  = ram_rd_data;
      bump_commit  = 1'b0;
      case (state_ff)
         ffa_pkg::SEQ_IDLE: begin
            ram_rd_addr = last_idx;
            if (accept) begin
               req_in = req_data.req_size;
               ptr_in = last_idx;
               if (req_data.func == ffa_pkg::FUNC_FREE) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.data_addr    = req_data.block_addr;
                  rsp_in.granted_size = req_data.req_size;
                  if (full) begin
                     rsp_in.status = ffa_pkg::ST_FULL;
                  end else begin
                     // push on top of the list
                     rsp_in.status    = ffa_pkg::ST_FREED;
                     ram_wr_en        = 1'b1;
                     ram_wr_addr      = IDX_W'(count_ff);
                     ram_wr_data.addr = req_data.block_addr;
                     ram_wr_data.size = req_data.req_size;
                     count_in         = count_ff + 1'b1;
                  end
               end
            end
         end
         ffa_pkg::SEQ_SCAN: begin
            ram_rd_addr = ptr_ff - 1'b1;
            if (hit) begin
               held_in = ram_rd_data;
               widx_in = ptr_ff;
               // start pulling the entry above down into the hole
               ram_rd_addr = ptr_ff + 1'b1;
               if (ptr_ff == last_idx) begin
                  count_in            = count_ff - 1'b1;
                  rsp_valid_in        = 1'b1;
                  rsp_in.data_addr    = ram_rd_data.addr;
                  rsp_in.granted_size = ram_rd_data.size;
                  rsp_in.status       = ffa_pkg::ST_REUSED;
               end
            end else begin
               ptr_in = ptr_ff - 1'b1;
            end
         end
         ffa_pkg::SEQ_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_rd_addr = IDX_W'(widx_ff + 2'd2);
            widx_in     = widx_ff + 1'b1;
            if (IDX_W'(widx_ff + 1'b1) == last_idx) begin
               count_in            = count_ff - 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_in.data_addr    = held_ff.addr;
               rsp_in.granted_size = held_ff.size;
               rsp_in.status       = ffa_pkg::ST_REUSED;
            end
         end
         ffa_pkg::SEQ_BUMP: begin
            rsp_valid_in = 1'b1;
            if (bump_status.fits) begin
               bump_commit         = 1'b1;
               rsp_in.data_addr    = bump_status.data_addr;
               rsp_in.granted_size = req_ff;
               rsp_in.status       = ffa_pkg::ST_BUMPED;
            end else begin
               rsp_in.data_addr    = '0;
               rsp_in.granted_size = '0;
               rsp_in.status       = ffa_pkg::ST_OOM;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffa_pkg::SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      widx_ff <= widx_in;
      req_ff  <= req_in;
      held_ff <= held_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = state_ff != ffa_pkg::SEQ_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign bump_size = req_ff;

   `FFA_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(FREE_ENTRIES), "free count overflow")
   `FFA_ASSERT(a_scan_in_list, clock, reset, (state_ff == ffa_pkg::SEQ_SCAN) |-> ({1'b0, ptr_ff} < {1'b0, count_ff}), "scan pointer beyond list")
   `FFA_ASSERT(a_shift_in_list, clock, reset, (state_ff == ffa_pkg::SEQ_SHIFT) |-> (widx_ff < last_idx), "shift index beyond list")
   `FFA_ASSERT(a_alloc_busy, clock, reset, (start && !busy && req_data.func == ffa_pkg::FUNC_ALLOC) |=> busy, "allocate did not raise busy")
   `FFA_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> (!rsp_valid && !busy), "activity right after reset")

endmodule

@@ src/first_fit_free_list_allocator.sv @@
// First-fit heap allocator with a LIFO free list: top level.
// Depends on ffa_pkg, ffa_ram, ffa_bump and ffa_seq.
//
// Usage:
//   Request channel: present req_data and raise start; the transfer happens at
//   the rising edge where start is high and busy is low.
//   Response channel: rsp_valid is high for exactly one cycle with rsp_data;
//   the receiver takes it at that edge and cannot stall it.
//   Configuration: csr_we with csr_wdata writes the heap size (bump limit) at
//   the edge; write only while the block is idle.
// Timing:
//   A free answers in the cycle after its transfer and leaves busy low, so a
//   new request can follow at once.
//   An allocate walks the free list held in the list memory one entry per
//   cycle from the newest, then shifts the entries above a hit down by one per
//   cycle through the same memory. A hit on the newest entry is answered from
//   the scan, any other hit after the shift, and a miss after the bump step
//   (entered from idle when the list is empty); busy is high until the cycle
//   of the answer, so the next transfer can share the edge that takes it.
// Reset: synchronous, active high; clears the free count, the frontier and the
// heap size to 2 GiB. The list memory needs no clearing.
module first_fit_free_list_allocator #(
   parameter int FREE_ENTRIES = ffa_pkg::FREE_ENTRIES_DEF,
   parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ffa_pkg::req_type req_data,
   output logic             rsp_valid,
   output ffa_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata
);

   localparam int IDX_W = $clog2(FREE_ENTRIES);

   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   logic [IDX_W-1:0]         ram_rd_addr;
   ffa_pkg::entry_type       ram_wr_data;
   ffa_pkg::entry_type       ram_rd_data;
   logic [30:0]              bump_size;
   logic                     bump_commit;
   ffa_pkg::bump_status_type bump_status;

   ffa_ram #(
      .WIDTH ($bits(ffa_pkg::entry_type)),
      .DEPTH (FREE_ENTRIES)
   ) u_list (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ffa_bump #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_bump (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_size  (bump_size),
      .commit    (bump_commit),
      .status    (bump_status)
   );

   ffa_seq #(
      .FREE_ENTRIES (FREE_ENTRIES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .bump_size   (bump_size),
      .bump_commit (bump_commit),
      .bump_status (bump_status),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule

@@ sim/tb_first_fit_free_list_allocator.sv @@
// Self-checking testbench for first_fit_free_list_allocator: directed and random
// allocate/free traffic, checked against a cycle-free heap tracker. Depends on ffa_pkg and the top level.
`timescale 1ns / 100ps

module tb_first_fit_free_list_allocator;
   import ffa_pkg::*;

   localparam int FREE_SLOTS = FREE_ENTRIES_DEF;
   localparam int HEADER = HEADER_BYTES_DEF;
   localparam int CYCLE_LIMIT = 400000;

   // Tracks the free list, frontier and heap size; holds the answers still due.
   class heap_tracker;
      logic [30:0] list_addr [FREE_SLOTS];
      logic [30:0] list_size [FREE_SLOTS];
      int          list_used = 0;
      logic [31:0] frontier = '0;
      logic [31:0] heap_bytes = HEAP_RESET;
      rsp_type     pending_answers[$];
      int          mismatches = 0;
      int          answers_checked = 0;
      int          status_seen [8];

      function rsp_type note_request(req_type r);
         rsp_type         answer;
         longint unsigned limit, data_start, data_end;
         int              hit;
         answer.data_addr = r.block_addr;
         answer.granted_size = r.req_size;
         hit = -1;
         if (r.func == FUNC_FREE) begin
            if (list_used >= FREE_SLOTS) begin
               answer.status = ST_FULL;
            end else begin
               list_addr[list_used] = r.block_addr;
               list_size[list_used] = r.req_size;
               list_used++;
               answer.status = ST_FREED;
            end
         end else begin
            // newest entry first
            for (int i = list_used - 1; i >= 0 && hit < 0; i--)
               if (list_size[i] >= r.req_size) hit = i;
            if (hit >= 0) begin
               answer.data_addr = list_addr[hit];
               answer.granted_size = list_size[hit];
               answer.status = ST_REUSED;
               for (int i = hit; i < list_used - 1; i++) begin
                  list_addr[i] = list_addr[i + 1];
                  list_size[i] = list_size[i + 1];
               end
               list_used--;
            end else begin
               limit = (heap_bytes < HEAP_LIMIT) ? heap_bytes : HEAP_LIMIT;
               data_start = frontier;
               data_start += HEADER;
               data_end = data_start + r.req_size;
               if (data_end > limit || data_start >= HEAP_LIMIT) begin
                  answer.data_addr = '0;
                  answer.granted_size = '0;
                  answer.status = ST_OOM;
               end else begin
                  frontier = data_end[31:0];
                  answer.data_addr = data_start[30:0];
                  answer.status = ST_BUMPED;
               end
            end
         end
         pending_answers.push_back(answer);
         return answer;
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected answer: addr %h size %h status %0d",
                        got.data_addr, got.granted_size, got.status);
            return;
         end
         want = pending_answers.pop_front();
         answers_checked++;
         status_seen[want.status]++;
         if (got.data_addr !== want.data_addr || got.granted_size !== want.granted_size ||
             got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("answer %0d: expected addr %h size %h status %0d, got addr %h size %h status %0d",
                        answers_checked, want.data_addr, want.granted_size, want.status,
                        got.data_addr, got.granted_size, got.status);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   heap_tracker tracker = new;
   entry_type   live_blocks[$];
   int          cycle_count = 0;
   int          heap_settings = 1;

   first_fit_free_list_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) tracker.check_answer(rsp_data);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Hold start until the transfer, then predict and remember live blocks.
   task automatic send_request(input req_type r);
      rsp_type answer;
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      answer = tracker.note_request(r);
      if (answer.status == ST_REUSED || answer.status == ST_BUMPED)
         live_blocks.push_back('{addr: answer.data_addr, size: answer.granted_size});
   endtask

   task automatic issue(input func_type f, input logic [30:0] size, input logic [30:0] addr);
      req_type r;
      r.func = f;
      r.req_size = size;
      r.block_addr = addr;
      send_request(r);
   endtask

   task automatic pause_sender(input int pct);
      int gaps;
      gaps = 0;
      while ($urandom_range(99) < pct) gaps++;
      if (gaps > 0) begin
         start <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (tracker.pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_heap(input logic [31:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.heap_bytes = value;
      heap_settings++;
   endtask

   function automatic logic [30:0] pick_size();
      case ($urandom_range(19))
         0:          return '0;
         1, 2:       return 31'($urandom);
         3, 4, 5, 6: return 31'($urandom_range(64));
         default:    return 31'($urandom_range(4095));
      endcase
   endfunction

   // Allocates or frees at random; frees are mostly of blocks really handed out, the rest bogus.
   function automatic req_type make_request(input int free_pct);
      req_type r;
      int      idx;
      r.block_addr = 31'($urandom);
      r.req_size = pick_size();
      r.func = FUNC_ALLOC;
      if ($urandom_range(99) < free_pct) begin
         r.func = FUNC_FREE;
         if (live_blocks.size() > 0 && $urandom_range(9) < 8) begin
            idx = $urandom_range(live_blocks.size() - 1);
            r.block_addr = live_blocks[idx].addr;
            r.req_size = live_blocks[idx].size;
            live_blocks.delete(idx);
         end
      end
      return r;
   endfunction

   task automatic run_phase(input int items, input int free_pct, input int gap_pct);
      repeat (items) begin
         pause_sender(gap_pct);
         send_request(make_request(free_pct));
      end
      wait_drained();
   endtask

   initial begin
      longint unsigned room;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part, heap size at its reset value
      issue(FUNC_ALLOC, 31'd0, 31'd0);
      issue(FUNC_ALLOC, 31'd100, 31'd0);
      issue(FUNC_ALLOC, 31'h7FFF_FFFF, 31'd0);
      issue(FUNC_FREE, 31'd100, 31'd32);
      issue(FUNC_FREE, 31'd0, 31'd16);
      issue(FUNC_ALLOC, 31'd50, 31'h7FFF_FFFF);
      issue(FUNC_ALLOC, 31'd0, 31'd0);
      issue(FUNC_FREE, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      issue(FUNC_FREE, 31'd0, 31'd0);
      issue(FUNC_FREE, 31'd100, 31'd32);
      issue(FUNC_ALLOC, 31'h7FFF_FFFF, 31'd0);
      issue(FUNC_ALLOC, 31'd100, 31'd0);
      issue(FUNC_ALLOC, 31'd1, 31'd0);
      issue(FUNC_ALLOC, 31'd0, 31'd0);
      wait_drained();
      // a bump ending exactly at the limit, then one past it
      write_heap(tracker.frontier + HEADER + 20);
      issue(FUNC_ALLOC, 31'd20, 31'd0);
      issue(FUNC_ALLOC, 31'd0, 31'd0);
      wait_drained();
      write_heap(32'd0);
      issue(FUNC_ALLOC, 31'd0, 31'd0);
      wait_drained();

      write_heap(32'h8000_0000);
      run_phase(125, 45, 0);
      write_heap(32'd0);
      run_phase(100, 40, 56);
      write_heap(tracker.frontier + 200000);
      run_phase(150, 85, 0);
      write_heap(32'hFFFF_FFFF);
      run_phase(125, 50, 15);

      // empty the list, then run the frontier up to the saturated limit
      while (tracker.list_used > 0) issue(FUNC_ALLOC, 31'd0, 31'd0);
      room = HEAP_LIMIT;
      if (room >= longint'(tracker.frontier) + HEADER) begin
         room = room - HEADER - tracker.frontier;
         issue(FUNC_ALLOC, room[30:0], 31'd0);
      end
      issue(FUNC_ALLOC, 31'd0, 31'd0);
      wait_drained();
      repeat (FREE_SLOTS + 4) @(posedge clock);

      $display("Checked %0d answers over %0d heap sizes: %0d reused, %0d bumped, %0d freed,",
               tracker.answers_checked, heap_settings, tracker.status_seen[ST_REUSED],
               tracker.status_seen[ST_BUMPED], tracker.status_seen[ST_FREED]);
      $display("  %0d out of memory, %0d dropped on a full list",
               tracker.status_seen[ST_OOM], tracker.status_seen[ST_FULL]);
      if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/ffa_pkg.sv
src/ffa_ram.sv
src/ffa_bump.sv
src/ffa_seq.sv
src/first_fit_free_list_allocator.sv
sim/tb_first_fit_free_list_allocator.sv
